// ===== rtl/core/dzct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dzct_pkg
// Shared types, codes and fixed-point constants of the dead-zone camera
// tracker. All positions are signed 20.12.
// ----------------------------------------------------------------------------
package dzct_pkg;

    // item function codes
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_SET_POS = 2'd1;
    localparam logic [1:0] FUNC_SET_LAG = 2'd2;

    // pose codes
    localparam logic [1:0] POSE_UP     = 2'd1;
    localparam logic [1:0] POSE_CROUCH = 2'd2;

    // configuration register indexes (byte address = 4 * index)
    localparam int          CFG_AW       = 4;
    localparam logic [1:0] REG_LEFT     = 2'd0;
    localparam logic [1:0] REG_RIGHT    = 2'd1;
    localparam logic [1:0] REG_TOP      = 2'd2;
    localparam logic [1:0] REG_BOTTOM   = 2'd3;

    localparam int DEF_LOOK_DELAY = 120;

    // reset values
    localparam logic signed [31:0] LEFT_RST    = 32'sd655360;
    localparam logic signed [31:0] RIGHT_RST   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] TOP_RST     = 32'sd491520;
    localparam logic signed [31:0] BOTTOM_RST  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] TRACK_X_RST = 32'sd655360;
    localparam logic signed [31:0] TRACK_Y_RST = 32'sd491520;

    // tracking arithmetic runs at 34 bits so sums and differences never wrap
    localparam logic signed [33:0] DZ_X       = 34'(8 << 12);
    localparam logic signed [33:0] DZ_Y       = 34'(32 << 12);
    localparam logic signed [33:0] CAP_X      = 34'(16 << 12);
    localparam logic signed [33:0] CAP_Y_AIR  = 34'(24 << 12);
    localparam logic signed [33:0] CAP_Y_GND  = 34'(6 << 12);
    localparam logic signed [33:0] S32_MAX_W  = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] S32_MIN_W  = -34'sh0_8000_0000;
    localparam logic signed [31:0] FAST_SPEED = 32'sh0000_6000;

    // offsets
    localparam logic signed [19:0] LEAD_X_MAX = 20'(64 << 12);
    localparam logic signed [19:0] STEP       = 20'(2 << 12);
    localparam logic signed [19:0] LEAD_UP    = 20'(104 << 12);
    localparam logic signed [19:0] LEAD_DOWN  = 20'(88 << 12);

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic               tracking;
        logic               airborne;
        logic signed [31:0] ground_speed;
        logic [1:0]         pose;
        logic [7:0]         lag_frames;
    } item_t;

    typedef struct packed {
        logic signed [31:0] track_x;
        logic signed [31:0] track_y;
        logic signed [19:0] lead_x;
        logic signed [19:0] lead_y;
        logic [7:0]         freeze_count;
    } cam_state_t;

    typedef struct packed {
        logic signed [31:0] left_limit;
        logic signed [31:0] right_limit;
        logic signed [31:0] top_limit;
        logic signed [31:0] bottom_limit;
    } limits_t;

endpackage
`default_nettype wire

// ===== rtl/core/dzct_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dzct_step
// One-item update of the camera state and the view it produces.
// ----------------------------------------------------------------------------
module dzct_step
    import dzct_pkg::*;
#(
    parameter int LOOK_DELAY = DEF_LOOK_DELAY,
    parameter int HOLD_W     = $clog2(LOOK_DELAY + 1)
)
(
    input  wire item_t             item,
    input  wire cam_state_t        cur,
    input  wire [HOLD_W-1:0]       hold_count,
    input  wire limits_t           limits,
    output cam_state_t             nxt,
    output logic [HOLD_W-1:0]      hold_next,
    output logic signed [31:0]     view_x,
    output logic signed [31:0]     view_y
);

    localparam logic [HOLD_W-1:0] HOLD_END = HOLD_W'(LOOK_DELAY);

    function automatic logic signed [33:0] dead_zone(
        input logic signed [31:0] pos,
        input logic signed [31:0] target,
        input logic signed [33:0] radius,
        input logic signed [33:0] cap
    );
        logic signed [33:0] p;
        logic signed [33:0] t;
        logic signed [33:0] d;
        p = 34'(pos);
        t = 34'(target);
        if (p + radius < t)
        begin
            d = t - (p + radius);
            dead_zone = (d > cap) ? cap : d;
        end
        else if (p - radius > t)
        begin
            d = t - (p - radius);
            dead_zone = (d < -cap) ? -cap : d;
        end
        else
        begin
            dead_zone = '0;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > S32_MAX_W)
            sat32 = S32_MAX_W[31:0];
        else if (v < S32_MIN_W)
            sat32 = S32_MIN_W[31:0];
        else
            sat32 = v[31:0];
    endfunction

    function automatic logic signed [19:0] retract(input logic signed [19:0] v);
        if (v > 20'sd0)
            retract = v - STEP;
        else if (v < 20'sd0)
            retract = v + STEP;
        else
            retract = '0;
    endfunction

    // below the minimum wins over above the maximum (inverted limits)
    function automatic logic signed [31:0] bound(
        input logic signed [32:0] v,
        input logic signed [31:0] lo,
        input logic signed [31:0] hi
    );
        if (v < 33'(lo))
            bound = lo;
        else if (v > 33'(hi))
            bound = hi;
        else
            bound = v[31:0];
    endfunction

    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] dy_gnd;
    logic signed [19:0] lead_y_hold;
    logic               fast;
    logic               looking;

    always_comb
    begin
        dx     = dead_zone(cur.track_x, item.x_value, DZ_X, CAP_X);
        dy_gnd = 34'(item.y_value) - 34'(cur.track_y);
        if (item.tracking && item.airborne)
            dy = dead_zone(cur.track_y, item.y_value, DZ_Y, CAP_Y_AIR);
        else if (dy_gnd > CAP_Y_GND)
            dy = CAP_Y_GND;
        else if (dy_gnd < -CAP_Y_GND)
            dy = -CAP_Y_GND;
        else
            dy = dy_gnd;

        fast    = (item.ground_speed >= FAST_SPEED) || (item.ground_speed <= -FAST_SPEED);
        looking = item.tracking && ((item.pose == POSE_UP) || (item.pose == POSE_CROUCH));

        nxt         = cur;
        hold_next   = hold_count;
        lead_y_hold = cur.lead_y;

        case (item.func)
            FUNC_SET_POS:
            begin
                nxt.track_x = item.x_value;
                nxt.track_y = item.y_value;
            end
            FUNC_SET_LAG:
            begin
                nxt.freeze_count = item.lag_frames;
            end
            FUNC_TICK:
            begin
                if (cur.freeze_count != 8'd0)
                begin
                    nxt.freeze_count = cur.freeze_count - 8'd1;
                end
                else
                begin
                    nxt.track_x = sat32(34'(cur.track_x) + dx);
                    nxt.track_y = sat32(34'(cur.track_y) + dy);

                    if (item.tracking && fast)
                    begin
                        if (item.ground_speed < 32'sd0 && cur.lead_x > -LEAD_X_MAX)
                            nxt.lead_x = cur.lead_x - STEP;
                        else if (item.ground_speed > 32'sd0 && cur.lead_x < LEAD_X_MAX)
                            nxt.lead_x = cur.lead_x + STEP;
                    end
                    else
                    begin
                        nxt.lead_x = retract(cur.lead_x);
                    end

                    if (looking)
                    begin
                        if (hold_count < HOLD_END)
                            hold_next = hold_count + HOLD_W'(1);
                        else if (item.pose == POSE_UP)
                            lead_y_hold = (cur.lead_y > -LEAD_UP) ? cur.lead_y - STEP : -LEAD_UP;
                        else
                            lead_y_hold = (cur.lead_y < LEAD_DOWN) ? cur.lead_y + STEP
                                                                   : LEAD_DOWN;
                    end
                    else
                    begin
                        hold_next = '0;
                    end

                    nxt.lead_y = (hold_next < HOLD_END) ? retract(lead_y_hold) : lead_y_hold;
                end
            end
            default:
            begin
                // unused code: state untouched, view of current state
            end
        endcase

        if (item.func == FUNC_SET_POS)
        begin
            view_x = item.x_value;
            view_y = item.y_value;
        end
        else
        begin
            view_x = bound(33'(nxt.track_x) + 33'(nxt.lead_x),
                           limits.left_limit, limits.right_limit);
            view_y = bound(33'(nxt.track_y) + 33'(nxt.lead_y),
                           limits.top_limit, limits.bottom_limit);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dead_zone_camera_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dead_zone_camera_tracker
// Per-frame dead-zone scroll camera with look-ahead and look-up/crouch pan.
// ----------------------------------------------------------------------------
// Usage: one transaction per video frame on the input channel (func selects
// frame tick, set position or set lag); every input transaction produces
// exactly one output transaction carrying view_x/view_y in signed 20.12.
// The block takes a new transaction every cycle while in_stall is low. An
// accepted transaction is held in the input register, then the whole camera
// update (dead zones, saturation, offsets, clamp to the limit registers)
// settles in one pass and lands in the tracker state and the result register
// at the same edge, so the next transaction already sees the updated state.
// in_stall rises only when both the input register and the result register
// are full and out_stall is high. Limit registers sit on the APB port at byte
// addresses 0x0, 0x4, 0x8, 0xC (left, right, top, bottom); write them only
// while no transaction is in flight.
// ----------------------------------------------------------------------------
module dead_zone_camera_tracker
    import dzct_pkg::*;
#(
    parameter int LOOK_DELAY = DEF_LOOK_DELAY
)
(
    input  wire                  clk,
    input  wire                  rst_n,

    // configuration port
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [CFG_AW-1:0]     paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,

    // input channel
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire [1:0]            func,
    input  wire signed [31:0]    x_value,
    input  wire signed [31:0]    y_value,
    input  wire                  tracking,
    input  wire                  airborne,
    input  wire signed [31:0]    ground_speed,
    input  wire [1:0]            pose,
    input  wire [7:0]            lag_frames,

    // output channel
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic signed [31:0]   view_x,
    output logic signed [31:0]   view_y
);

    localparam int HOLD_W = $clog2(LOOK_DELAY + 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    limits_t limits_reg;
    logic    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.left_limit   <= LEFT_RST;
            limits_reg.right_limit  <= RIGHT_RST;
            limits_reg.top_limit    <= TOP_RST;
            limits_reg.bottom_limit <= BOTTOM_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_LEFT:   limits_reg.left_limit   <= pwdata;
                REG_RIGHT:  limits_reg.right_limit  <= pwdata;
                REG_TOP:    limits_reg.top_limit    <= pwdata;
                REG_BOTTOM: limits_reg.bottom_limit <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LEFT:   prdata = limits_reg.left_limit;
            REG_RIGHT:  prdata = limits_reg.right_limit;
            REG_TOP:    prdata = limits_reg.top_limit;
            REG_BOTTOM: prdata = limits_reg.bottom_limit;
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: input register -> update -> result register
    // ------------------------------------------------------------------
    logic  s1_valid_reg;
    item_t s1_item_reg;
    logic  out_valid_reg;
    logic  out_block;
    logic  s1_fire;
    logic  in_accept;

    assign out_block = out_valid_reg && out_stall;
    assign s1_fire   = s1_valid_reg && !out_block;
    assign in_stall  = s1_valid_reg && out_block;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.func         <= func;
            s1_item_reg.x_value      <= x_value;
            s1_item_reg.y_value      <= y_value;
            s1_item_reg.tracking     <= tracking;
            s1_item_reg.airborne     <= airborne;
            s1_item_reg.ground_speed <= ground_speed;
            s1_item_reg.pose         <= pose;
            s1_item_reg.lag_frames   <= lag_frames;
        end
    end

    // ------------------------------------------------------------------
    // camera state and update
    // ------------------------------------------------------------------
    cam_state_t         state_reg;
    cam_state_t         state_next;
    logic [HOLD_W-1:0]  hold_reg;
    logic [HOLD_W-1:0]  hold_next;
    logic signed [31:0] view_x_next;
    logic signed [31:0] view_y_next;
    logic signed [31:0] view_x_reg;
    logic signed [31:0] view_y_reg;

    dzct_step #(
        .LOOK_DELAY (LOOK_DELAY),
        .HOLD_W     (HOLD_W)
    ) u_step (
        .item       (s1_item_reg),
        .cur        (state_reg),
        .hold_count (hold_reg),
        .limits     (limits_reg),
        .nxt        (state_next),
        .hold_next  (hold_next),
        .view_x     (view_x_next),
        .view_y     (view_y_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.track_x      <= TRACK_X_RST;
            state_reg.track_y      <= TRACK_Y_RST;
            state_reg.lead_x       <= '0;
            state_reg.lead_y       <= '0;
            state_reg.freeze_count <= '0;
            hold_reg               <= '0;
        end
        else if (s1_fire)
        begin
            state_reg <= state_next;
            hold_reg  <= hold_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            view_x_reg <= view_x_next;
            view_y_reg <= view_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign view_x    = view_x_reg;
    assign view_y    = view_y_reg;

endmodule
`default_nettype wire

// ===== rtl/core/dzct_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dzct_checker
// Port-level checks on the camera tracker, bound to the top level.
// ----------------------------------------------------------------------------
module dzct_checker
    import dzct_pkg::*;
(
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_stall,
    input wire [1:0]          func,
    input wire signed [31:0]  x_value,
    input wire signed [31:0]  y_value,
    input wire                out_valid,
    input wire                out_stall,
    input wire signed [31:0]  view_x,
    input wire signed [31:0]  view_y
);

    // a held result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(view_x) && $stable(view_y))
        else $error("result changed while stalled");

    // backpressure only comes from a blocked result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with result path free");

    // set position passes straight through to the view
    a_set_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && func == FUNC_SET_POS && !out_valid) ##1 !out_stall
        |=> out_valid && view_x == $past(x_value, 2) && view_y == $past(y_value, 2))
        else $error("set position result wrong");

endmodule

bind dead_zone_camera_tracker dzct_checker u_dzct_checker (.*);
`default_nettype wire
